// ===== sv/rgbhsv_pkg.sv =====
// rgbhsv_pkg: shared types and constants for the rgb to hsv pixel core
// used by rgbhsv_prep, rgbhsv_div_cell and rgb_to_hsv_pixel_core
// no dependencies
`default_nettype none

package rgbhsv_pkg;

   // channel and result widths
   localparam int ChanBits  = 8;
   localparam int QuoBits   = 16;
   localparam int HueRemBits = 11;   // 6 * chroma <= 1530
   localparam int SatRemBits = 9;    // 2 * value <= 510

   // hue sector offsets and a full turn, in units of chroma
   localparam int GreenOffset = 2;
   localparam int BlueOffset  = 4;
   localparam int Sectors     = 6;

   // stream payload widths
   localparam int ReqDataBits = 24;
   localparam int RspDataBits = 40;

   // one transaction as it travels down the divider chain
   typedef struct packed {
      logic [HueRemBits-1:0] hue_rem;
      logic [HueRemBits-1:0] hue_div;
      logic [SatRemBits-1:0] sat_rem;
      logic [SatRemBits-1:0] sat_div;
      logic [QuoBits-1:0]    hue_quo;
      logic [QuoBits-1:0]    sat_quo;
      logic [ChanBits-1:0]   brightness;
      logic                  hue_zero;
      logic                  sat_zero;
   } lane_type;

endpackage

`default_nettype wire

// ===== sv/rgb_to_hsv_pixel_core.sv =====
// rgb_to_hsv_pixel_core: top level of the rgb to hsv pixel converter
// depends on rgbhsv_pkg, rgbhsv_prep and rgbhsv_div_cell
`default_nettype none

// Converts one 8-bit rgb pixel per clock, while no stall backs up to the
// front, into hue (16-bit fraction of a turn), saturation (Q1.15) and
// brightness (channel maximum). A pixel passes through a front stage that
// finds the extremes and the hue sector, then through 16 division cells,
// each of which produces one quotient bit of both the hue and the
// saturation division. Every stage has its own valid bit and register, so
// a new pixel is taken in every cycle unless a stall has backed up to the
// front stage, and empty stages close up while the result side stalls.
// Grey pixels give hue 0 and black pixels give saturation 0.

module rgb_to_hsv_pixel_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  wire logic [rgbhsv_pkg::ReqDataBits-1:0]  req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // hue [15:0], saturation [31:16], brightness [39:32]
   output logic [rgbhsv_pkg::RspDataBits-1:0]       rsp_tdata
);

   localparam int Cells = rgbhsv_pkg::QuoBits;

   logic                 link_valid [Cells+1];
   logic                 link_ready [Cells+1];
   rgbhsv_pkg::lane_type link_data  [Cells+1];
   rgbhsv_pkg::lane_type last;

   // front stage
   rgbhsv_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .red        (req_tdata[7:0]),
      .green      (req_tdata[15:8]),
      .blue       (req_tdata[23:16]),
      .down_valid (link_valid[0]),
      .down_ready (link_ready[0]),
      .down_data  (link_data[0])
   );

   // chain of division cells, most significant quotient bit first
   for (genvar i = 0; i < Cells; i++) begin : g_cell
      rgbhsv_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[i]),
         .up_ready   (link_ready[i]),
         .up_data    (link_data[i]),
         .down_valid (link_valid[i+1]),
         .down_ready (link_ready[i+1]),
         .down_data  (link_data[i+1])
      );
   end

   // result transaction, zero cases masked
   assign last              = link_data[Cells];
   assign rsp_tvalid        = link_valid[Cells];
   assign link_ready[Cells] = rsp_tready;
   assign rsp_tdata[15:0]   = last.hue_zero ? '0 : last.hue_quo;
   assign rsp_tdata[31:16]  = last.sat_zero ? '0 : last.sat_quo;
   assign rsp_tdata[39:32]  = last.brightness;

endmodule

`default_nettype wire

// ===== sv/rgbhsv_prep.sv =====
// rgbhsv_prep: head of the chain; finds max, min, hue sector and the
// numerators and divisors for hue and saturation, one registered stage
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_prep (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         up_valid,
   output logic                              up_ready,
   input  wire logic [rgbhsv_pkg::ChanBits-1:0] red,
   input  wire logic [rgbhsv_pkg::ChanBits-1:0] green,
   input  wire logic [rgbhsv_pkg::ChanBits-1:0] blue,
   output logic                              down_valid,
   input  wire logic                         down_ready,
   output rgbhsv_pkg::lane_type              down_data
);

   logic                 valid_ff;
   logic                 valid_in;
   rgbhsv_pkg::lane_type data_ff;
   rgbhsv_pkg::lane_type data_in;

   logic [7:0]         max_rg;
   logic [7:0]         min_rg;
   logic [7:0]         vmax;
   logic [7:0]         vmin;
   logic [7:0]         chroma;
   logic signed [11:0] c_s;
   logic signed [11:0] num;
   logic signed [11:0] num_wrap;
   logic [10:0]        six_c;

   // channel extremes
   always_comb begin
      max_rg = (red > green) ? red : green;
      vmax   = (max_rg > blue) ? max_rg : blue;
      min_rg = (red < green) ? red : green;
      vmin   = (min_rg < blue) ? min_rg : blue;
      chroma = vmax - vmin;
      c_s    = $signed({4'b0, chroma});
      six_c  = {1'b0, chroma, 2'b0} + {2'b0, chroma, 1'b0};
   end

   // sector numerator, blue wins ties, then green
   always_comb begin
      priority if (blue == vmax) begin
         num = (c_s <<< 2) + $signed({4'b0, red}) - $signed({4'b0, green});
      end else if (green == vmax) begin
         num = (c_s <<< 1) + $signed({4'b0, blue}) - $signed({4'b0, red});
      end else begin
         num = $signed({4'b0, green}) - $signed({4'b0, blue});
      end
      // negative hue wraps by one full turn
      num_wrap = num[11] ? num + $signed({1'b0, six_c}) : num;
   end

   // next stage contents
   always_comb begin
      data_in.hue_rem    = num_wrap[10:0];
      data_in.hue_div    = six_c;
      data_in.sat_rem    = {1'b0, chroma};
      data_in.sat_div    = {vmax, 1'b0};
      data_in.hue_quo    = '0;
      data_in.sat_quo    = '0;
      data_in.brightness = vmax;
      data_in.hue_zero   = (chroma == 8'd0);
      data_in.sat_zero   = (vmax == 8'd0);
   end

   // stage handshake, bubbles collapse
   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/rgbhsv_div_cell.sv =====
// rgbhsv_div_cell: one restoring division step for both the hue and the
// saturation lane; produces one quotient bit per lane and hands on
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_div_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output logic                      up_ready,
   input  wire rgbhsv_pkg::lane_type up_data,
   output logic                      down_valid,
   input  wire logic                 down_ready,
   output rgbhsv_pkg::lane_type      down_data
);

   logic                 valid_ff;
   logic                 valid_in;
   rgbhsv_pkg::lane_type data_ff;
   rgbhsv_pkg::lane_type data_in;

   logic [rgbhsv_pkg::HueRemBits:0] hue_dbl;
   logic [rgbhsv_pkg::HueRemBits:0] hue_sub;
   logic                            hue_bit;
   logic [rgbhsv_pkg::SatRemBits:0] sat_dbl;
   logic [rgbhsv_pkg::SatRemBits:0] sat_sub;
   logic                            sat_bit;

   // shift remainder, compare against divisor, subtract when it fits
   always_comb begin
      hue_dbl = {up_data.hue_rem, 1'b0};
      hue_sub = hue_dbl - {1'b0, up_data.hue_div};
      hue_bit = (hue_dbl >= {1'b0, up_data.hue_div});
      sat_dbl = {up_data.sat_rem, 1'b0};
      sat_sub = sat_dbl - {1'b0, up_data.sat_div};
      sat_bit = (sat_dbl >= {1'b0, up_data.sat_div});

      data_in         = up_data;
      data_in.hue_rem = hue_bit ? hue_sub[rgbhsv_pkg::HueRemBits-1:0]
                                : hue_dbl[rgbhsv_pkg::HueRemBits-1:0];
      data_in.sat_rem = sat_bit ? sat_sub[rgbhsv_pkg::SatRemBits-1:0]
                                : sat_dbl[rgbhsv_pkg::SatRemBits-1:0];
      data_in.hue_quo = {up_data.hue_quo[rgbhsv_pkg::QuoBits-2:0], hue_bit};
      data_in.sat_quo = {up_data.sat_quo[rgbhsv_pkg::QuoBits-2:0], sat_bit};
   end

   // stage handshake, bubbles collapse
   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/rgbhsv_checker.sv =====
// rgbhsv_checker: port-level assertions for rgb_to_hsv_pixel_core
// bound to the top level below; no package dependency
`default_nettype none

module rgbhsv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // black pixel has no saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:32] != 8'd0) || (rsp_tdata[31:16] == 16'd0))
      else $error("saturation nonzero on black pixel");

   // saturation never exceeds one
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[31] && (rsp_tdata[30:16] != 15'd0)))
      else $error("saturation above one");

   // zero saturation means grey, so hue is zero
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[31:16] == 16'd0) |-> rsp_tdata[15:0] == 16'd0)
      else $error("hue nonzero on grey pixel");

endmodule

bind rgb_to_hsv_pixel_core rgbhsv_checker u_rgbhsv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for rgb_to_hsv_pixel_core, directed and random pixels
// with random idling on both stream sides and a scoreboard fed by a local hsv predictor
// depends on rgbhsv_pkg and rgb_to_hsv_pixel_core
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ChanBits    = rgbhsv_pkg::ChanBits;
   localparam int QuoBits     = rgbhsv_pkg::QuoBits;
   localparam int ReqDataBits = rgbhsv_pkg::ReqDataBits;
   localparam int RspDataBits = rgbhsv_pkg::RspDataBits;
   localparam int GreenOffset = rgbhsv_pkg::GreenOffset;
   localparam int BlueOffset  = rgbhsv_pkg::BlueOffset;
   localparam int Sectors     = rgbhsv_pkg::Sectors;

   localparam int RandomPixels = 1750;
   localparam int CalmPixels   = 200;    // no idling once this few are left
   localparam int StallLimit   = 2000;   // cycles with no transaction on either side
   localparam int SettleCycles = 40;     // pipeline is 17 deep

   // one converted pixel, laid out as on rsp_tdata
   typedef struct packed {
      logic [ChanBits-1:0] brightness;
      logic [QuoBits-1:0]  saturation;
      logic [QuoBits-1:0]  hue;
   } hsv_type;

   // a pixel to send, or a pause until every result is back
   typedef struct packed {
      logic                   drain;
      logic [ReqDataBits-1:0] pixel;
   } job_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;       // hue [15:0], saturation [31:16], brightness [39:32]

   job_type pixel_jobs[$];
   hsv_type hsv_due[$];
   int      fault_count = 0;
   int      idle_cycles = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   logic    calm = 1'b0;

   rgb_to_hsv_pixel_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // exact integer hsv of one pixel
   function automatic hsv_type hsv_of(logic [ReqDataBits-1:0] pixel);
      int      red;
      int      green;
      int      blue;
      int      top;
      int      bottom;
      int      chroma;
      int      numer;
      hsv_type res;
      red    = int'(pixel[7:0]);
      green  = int'(pixel[15:8]);
      blue   = int'(pixel[23:16]);
      top    = (red > green) ? red : green;
      top    = (top > blue) ? top : blue;
      bottom = (red < green) ? red : green;
      bottom = (bottom < blue) ? bottom : blue;
      chroma = top - bottom;
      res.brightness = top[ChanBits-1:0];
      res.saturation = '0;
      res.hue        = '0;
      // black pixel keeps saturation zero
      if (top != 0) begin
         res.saturation = QuoBits'((longint'(chroma) * 32768) / top);
      end
      // grey pixel keeps hue zero; ties go blue, then green, then red
      if (chroma != 0) begin
         if (top == blue) begin
            numer = BlueOffset * chroma + (red - green);
         end else if (top == green) begin
            numer = GreenOffset * chroma + (blue - red);
         end else begin
            numer = green - blue;
         end
         // red sector with green below blue wraps by a full turn
         if (numer < 0) begin
            numer = numer + Sectors * chroma;
         end
         res.hue = QuoBits'((longint'(numer) * 65536) / (Sectors * chroma));
      end
      return res;
   endfunction

   task automatic add_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
      pixel_jobs.push_back('{drain: 1'b0, pixel: {blue, green, red}});
   endtask

   task automatic add_drain();
      pixel_jobs.push_back('{drain: 1'b1, pixel: '0});
   endtask

   // request driver: holds a pixel until taken, otherwise pulls the next job
   always @(posedge clock) begin : drive
      logic                   next_valid;
      logic [ReqDataBits-1:0] next_data;
      job_type                job;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         next_valid = req_tvalid;
         next_data  = req_tdata;
         if (req_tvalid && req_tready) begin
            hsv_due.push_back(hsv_of(req_tdata));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pixel_jobs.size() > 0) begin
               if (pixel_jobs[0].drain) begin
                  if (hsv_due.size() == 0) begin
                     void'(pixel_jobs.pop_front());
                  end
               end else begin
                  job        = pixel_jobs.pop_front();
                  next_valid = 1'b1;
                  next_data  = job.pixel;
                  if (!calm && $urandom_range(0, 11) == 0) begin
                     gap_left = $urandom_range(1, 19);
                  end
               end
            end
         end
         req_tvalid <= next_valid;
         req_tdata  <= next_data;
         calm       <= (pixel_jobs.size() < CalmPixels);
      end
   end

   // result monitor: compares each transaction with the oldest prediction
   always @(posedge clock) begin : watch
      hsv_type seen;
      hsv_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (hsv_due.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected result: expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               due = hsv_due.pop_front();
               if (seen.hue !== due.hue) begin
                  fault_count++;
                  $display("%0t: hue mismatch: expected %0d, actual %0d",
                           $time, due.hue, seen.hue);
               end
               if (seen.saturation !== due.saturation) begin
                  fault_count++;
                  $display("%0t: saturation mismatch: expected %0d, actual %0d",
                           $time, due.saturation, seen.saturation);
               end
               if (seen.brightness !== due.brightness) begin
                  fault_count++;
                  $display("%0t: brightness mismatch: expected %0d, actual %0d",
                           $time, due.brightness, seen.brightness);
               end
            end
         end
         // random back-pressure bursts
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int top;
      int low;
      int base;
      // extremes, pure colors, grey and black
      add_pixel(8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd128, 8'd128, 8'd128);
      add_pixel(8'd1, 8'd1, 8'd1);
      add_pixel(8'd255, 8'd0, 8'd0);
      add_pixel(8'd0, 8'd255, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd255);
      // ties for the maximum
      add_pixel(8'd255, 8'd255, 8'd0);
      add_pixel(8'd0, 8'd255, 8'd255);
      add_pixel(8'd255, 8'd0, 8'd255);
      add_pixel(8'd200, 8'd200, 8'd7);
      add_pixel(8'd9, 8'd77, 8'd77);
      add_pixel(8'd77, 8'd9, 8'd77);
      // red sector with negative hue, and its positive twin
      add_pixel(8'd255, 8'd0, 8'd10);
      add_pixel(8'd255, 8'd10, 8'd0);
      add_pixel(8'd255, 8'd0, 8'd254);
      // smallest chroma and value
      add_pixel(8'd1, 8'd0, 8'd0);
      add_pixel(8'd0, 8'd1, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd1);
      add_pixel(8'd254, 8'd255, 8'd253);
      add_pixel(8'd255, 8'd254, 8'd255);
      add_pixel(8'd170, 8'd85, 8'd51);
      add_drain();
      // random part: uniform, near grey, dark, and forced ties
      for (int i = 0; i < RandomPixels; i++) begin
         if (i == RandomPixels / 2) begin
            add_drain();
         end
         case ($urandom_range(0, 3))
            0: add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            1: begin
               base = $urandom_range(0, 251);
               add_pixel(8'(base + $urandom_range(0, 4)), 8'(base + $urandom_range(0, 4)),
                         8'(base + $urandom_range(0, 4)));
            end
            2: add_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                         8'($urandom_range(0, 3)));
            default: begin
               top = $urandom_range(0, 255);
               low = $urandom_range(0, top);
               case ($urandom_range(0, 2))
                  0: add_pixel(8'(top), 8'(top), 8'(low));
                  1: add_pixel(8'(top), 8'(low), 8'(top));
                  default: add_pixel(8'(low), 8'(top), 8'(top));
               endcase
            end
         endcase
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pixel_jobs.size() > 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (hsv_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
